[rtl/core/gbf_pkg.sv]
package gbf_pkg;

	localparam int unsigned MaxVertices = 64;
	localparam int unsigned MaxEdges    = 256;
	localparam int unsigned VtxW        = 6;
	localparam int unsigned SlotW       = 9;
	localparam int unsigned LinkW       = 10;
	localparam int unsigned CountW      = 7;

	localparam logic [LinkW-1:0]  NilLink  = 10'd512;
	localparam logic [CountW-1:0] NoParent = 7'd64;
	localparam logic [CountW-1:0] VcReset  = 7'd64;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_L0,
		ST_L1,
		ST_L2,
		ST_L3,
		ST_ROOT,
		ST_HEAD,
		ST_CUR,
		ST_NB,
		ST_DISC,
		ST_POP,
		ST_FINISH
	} gbf_state_t;

	typedef struct packed {
		logic [SlotW-1:0] head;
		logic [SlotW-1:0] tail;
	} gbf_list_t;

	typedef struct packed {
		logic [VtxW-1:0]   vertex;
		logic [CountW-1:0] parent;
		logic [LinkW-1:0]  cursor;
		logic [VtxW-1:0]   low;
		logic [VtxW-1:0]   disc;
	} gbf_frame_t;

endpackage

[rtl/core/gbf_edge_if.sv]
interface gbf_edge_if;
	logic       valid;
	logic       ready;
	logic       has_edge;
	logic [5:0] end_u;
	logic [5:0] end_v;
	logic       last_edge;

	modport source(output valid, has_edge, end_u, end_v, last_edge, input ready);
	modport sink(input valid, has_edge, end_u, end_v, last_edge, output ready);
endinterface

[rtl/core/gbf_bridge_if.sv]
interface gbf_bridge_if;
	logic       valid;
	logic       ready;
	logic       bridge_found;
	logic [5:0] bridge_u;
	logic [5:0] bridge_v;
	logic       last_result;
	logic       edges_dropped;

	modport source(output valid, bridge_found, bridge_u, bridge_v, last_result,
		edges_dropped, input ready);
	modport sink(input valid, bridge_found, bridge_u, bridge_v, last_result,
		edges_dropped, output ready);
endinterface

[rtl/core/graph_bridge_finder_top.sv]
// Sequence: an edge word is accepted and then runs the list updates L0 to L3; a word with no
//   edge, or a dropped edge, is only accepted. The last word then runs the walk over all
//   vertices and stored edges, which output stalls can hold.
// Throughput: one word at a time; an edge word runs L0 to L3 before the next word is taken.
// Reset: arst_n clears control, flags and valid bits at once; no clearing pass is needed,
//   and the marks and counters, not the memories, are cleared the same way in the cycle that loads the final result.
module graph_bridge_finder_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gbf_pkg::CountW-1:0]   cfg_wdata,
	gbf_edge_if.sink                     edges,
	gbf_bridge_if.source                 bridges
);

	// Memories: adjacency slots, list head/tail, discovery times and the suspended stack.
	logic [gbf_pkg::VtxW-1:0]     nb_mem   [2*gbf_pkg::MaxEdges];
	logic [gbf_pkg::LinkW-1:0]    nx_mem   [2*gbf_pkg::MaxEdges];
	gbf_pkg::gbf_list_t           ht_mem   [gbf_pkg::MaxVertices];
	logic [gbf_pkg::VtxW-1:0]     disc_mem [gbf_pkg::MaxVertices];
	gbf_pkg::gbf_frame_t          stk_mem  [gbf_pkg::MaxVertices];

	logic [gbf_pkg::VtxW-1:0]     nb_rd;
	logic [gbf_pkg::LinkW-1:0]    nx_rd;
	gbf_pkg::gbf_list_t           ht_rd;
	logic [gbf_pkg::VtxW-1:0]     disc_rd;
	gbf_pkg::gbf_frame_t          stk_rd;

	gbf_pkg::gbf_state_t          state_q, state_d;
	logic [gbf_pkg::CountW-1:0]   vc_q;
	logic [gbf_pkg::SlotW-1:0]    et_q;
	logic                         drop_q;
	logic [gbf_pkg::MaxVertices-1:0] vis_q;
	logic [gbf_pkg::MaxVertices-1:0] hv_q;
	logic [gbf_pkg::VtxW-1:0]     depth_q;
	logic [gbf_pkg::VtxW-1:0]     timer_q;
	logic [gbf_pkg::CountW-1:0]   root_q;
	logic [gbf_pkg::VtxW-1:0]     u_q, v_q;
	logic                         last_q;

	// Top of stack lives in registers.
	logic [gbf_pkg::VtxW-1:0]     node_q;
	logic [gbf_pkg::CountW-1:0]   par_q;
	logic [gbf_pkg::LinkW-1:0]    cur_q;
	logic [gbf_pkg::VtxW-1:0]     low_q;
	logic [gbf_pkg::VtxW-1:0]     disc_q;

	// One bridge is held back so the final one can carry last_result.
	logic                         pend_q;
	logic [gbf_pkg::VtxW-1:0]     pend_u_q, pend_v_q;

	logic                         out_valid_q;
	logic                         out_found_q, out_last_q, out_drop_q;
	logic [gbf_pkg::VtxW-1:0]     out_u_q, out_v_q;

	logic [gbf_pkg::CountW-1:0]   nv;
	logic                         acc, bad_edge;
	logic [gbf_pkg::SlotW-1:0]    slot0, slot1;
	logic                         out_free, hit_parent, bridge, pop_stall;
	logic                         out_load;
	logic                         visit;
	logic [gbf_pkg::VtxW-1:0]     vnode;
	logic [gbf_pkg::CountW-1:0]   vpar;

	logic                         ht_re, ht_we, nb_we, nx_we, nx_re;
	logic [gbf_pkg::VtxW-1:0]     ht_ra, ht_wa;
	gbf_pkg::gbf_list_t           ht_wd;
	logic [gbf_pkg::SlotW-1:0]    nb_wa, nx_wa;
	logic [gbf_pkg::VtxW-1:0]     nb_wd;
	logic [gbf_pkg::LinkW-1:0]    nx_wd;

	assign nv       = (vc_q > gbf_pkg::VcReset) ? gbf_pkg::VcReset : vc_q;
	assign acc      = edges.valid && edges.ready;
	assign edges.ready = (state_q == gbf_pkg::ST_IDLE);
	assign bad_edge = ({1'b0, edges.end_u} >= nv) || ({1'b0, edges.end_v} >= nv) || et_q[8];
	assign slot0    = {et_q[7:0], 1'b0};
	assign slot1    = {et_q[7:0], 1'b1};
	assign out_free = !out_valid_q || bridges.ready;
	assign hit_parent = ({1'b0, nb_rd} == par_q);
	assign bridge   = (low_q > stk_rd.disc);
	assign pop_stall = (state_q == gbf_pkg::ST_POP) && bridge && pend_q && !out_free;
	// A new output word is loaded in this cycle.
	assign out_load = ((state_q == gbf_pkg::ST_POP) && !pop_stall && bridge && pend_q) ||
		((state_q == gbf_pkg::ST_FINISH) && out_free);

	assign bridges.valid         = out_valid_q;
	assign bridges.bridge_found  = out_found_q;
	assign bridges.bridge_u      = out_u_q;
	assign bridges.bridge_v      = out_v_q;
	assign bridges.last_result   = out_last_q;
	assign bridges.edges_dropped = out_drop_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gbf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory port control.
	always_comb begin
		state_d = state_q;
		visit   = 1'b0;
		vnode   = root_q[gbf_pkg::VtxW-1:0];
		vpar    = gbf_pkg::NoParent;
		ht_re   = 1'b0;
		ht_ra   = u_q;
		ht_we   = 1'b0;
		ht_wa   = u_q;
		ht_wd   = '{head: slot0, tail: slot0};
		nb_we   = 1'b0;
		nb_wa   = slot0;
		nb_wd   = v_q;
		nx_we   = 1'b0;
		nx_wa   = slot0;
		nx_wd   = gbf_pkg::NilLink;
		nx_re   = 1'b0;
		unique case (state_q)
			gbf_pkg::ST_IDLE: begin
				if (acc) begin
					if (edges.has_edge && !bad_edge) begin
						state_d = gbf_pkg::ST_L0;
					end else if (edges.last_edge) begin
						state_d = gbf_pkg::ST_ROOT;
					end
				end
			end
			gbf_pkg::ST_L0: begin
				// fetch list of u, lay down the forward slot
				ht_re = 1'b1;
				nb_we = 1'b1;
				nx_we = 1'b1;
				state_d = gbf_pkg::ST_L1;
			end
			gbf_pkg::ST_L1: begin
				ht_we = 1'b1;
				ht_wd = '{head: hv_q[u_q] ? ht_rd.head : slot0, tail: slot0};
				nx_we = hv_q[u_q];
				nx_wa = ht_rd.tail;
				nx_wd = {1'b0, slot0};
				state_d = gbf_pkg::ST_L2;
			end
			gbf_pkg::ST_L2: begin
				// read of v issued after u's write, so a self loop sees it
				ht_re = 1'b1;
				ht_ra = v_q;
				nb_we = 1'b1;
				nb_wa = slot1;
				nb_wd = u_q;
				nx_we = 1'b1;
				nx_wa = slot1;
				state_d = gbf_pkg::ST_L3;
			end
			gbf_pkg::ST_L3: begin
				ht_we = 1'b1;
				ht_wa = v_q;
				ht_wd = '{head: hv_q[v_q] ? ht_rd.head : slot1, tail: slot1};
				nx_we = hv_q[v_q];
				nx_wa = ht_rd.tail;
				nx_wd = {1'b0, slot1};
				state_d = last_q ? gbf_pkg::ST_ROOT : gbf_pkg::ST_IDLE;
			end
			gbf_pkg::ST_ROOT: begin
				if (root_q >= nv) begin
					state_d = gbf_pkg::ST_FINISH;
				end else if (!vis_q[root_q[gbf_pkg::VtxW-1:0]]) begin
					visit   = 1'b1;
					state_d = gbf_pkg::ST_HEAD;
				end
			end
			gbf_pkg::ST_HEAD: begin
				state_d = gbf_pkg::ST_CUR;
			end
			gbf_pkg::ST_CUR: begin
				if (cur_q[gbf_pkg::LinkW-1]) begin
					state_d = (depth_q == '0) ? gbf_pkg::ST_ROOT : gbf_pkg::ST_POP;
				end else begin
					nx_re   = 1'b1;
					state_d = gbf_pkg::ST_NB;
				end
			end
			gbf_pkg::ST_NB: begin
				if (hit_parent) begin
					state_d = gbf_pkg::ST_CUR;
				end else if (!vis_q[nb_rd]) begin
					visit   = 1'b1;
					vnode   = nb_rd;
					vpar    = {1'b0, node_q};
					state_d = gbf_pkg::ST_HEAD;
				end else begin
					state_d = gbf_pkg::ST_DISC;
				end
			end
			gbf_pkg::ST_DISC: begin
				state_d = gbf_pkg::ST_CUR;
			end
			gbf_pkg::ST_POP: begin
				if (!pop_stall) begin
					state_d = gbf_pkg::ST_CUR;
				end
			end
			gbf_pkg::ST_FINISH: begin
				if (out_free) begin
					state_d = gbf_pkg::ST_IDLE;
				end
			end
			default: state_d = gbf_pkg::ST_IDLE;
		endcase
		if (visit) begin
			ht_re = 1'b1;
			ht_ra = vnode;
		end
	end

	// Memories: synchronous, registered read.
	always_ff @(posedge clk) begin
		if (nb_we) begin
			nb_mem[nb_wa] <= nb_wd;
		end
		if (nx_we) begin
			nx_mem[nx_wa] <= nx_wd;
		end
		if (nx_re) begin
			nb_rd <= nb_mem[cur_q[gbf_pkg::SlotW-1:0]];
			nx_rd <= nx_mem[cur_q[gbf_pkg::SlotW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (ht_we) begin
			ht_mem[ht_wa] <= ht_wd;
		end
		if (ht_re) begin
			ht_rd <= ht_mem[ht_ra];
		end
	end

	always_ff @(posedge clk) begin
		if (visit) begin
			disc_mem[vnode] <= timer_q;
		end
		if (state_q == gbf_pkg::ST_NB) begin
			disc_rd <= disc_mem[nb_rd];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == gbf_pkg::ST_NB && !hit_parent && !vis_q[nb_rd]) begin
			stk_mem[depth_q] <= '{vertex: node_q, parent: par_q, cursor: nx_rd,
				low: low_q, disc: disc_q};
		end
		if (state_q == gbf_pkg::ST_CUR && cur_q[gbf_pkg::LinkW-1] && depth_q != '0) begin
			stk_rd <= stk_mem[depth_q - 1'b1];
		end
	end

	// Control and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vc_q        <= gbf_pkg::VcReset;
			et_q        <= '0;
			drop_q      <= 1'b0;
			vis_q       <= '0;
			hv_q        <= '0;
			depth_q     <= '0;
			timer_q     <= '0;
			root_q      <= '0;
			u_q         <= '0;
			v_q         <= '0;
			last_q      <= 1'b0;
			node_q      <= '0;
			par_q       <= gbf_pkg::NoParent;
			cur_q       <= gbf_pkg::NilLink;
			low_q       <= '0;
			disc_q      <= '0;
			pend_q      <= 1'b0;
			pend_u_q    <= '0;
			pend_v_q    <= '0;
			out_valid_q <= 1'b0;
			out_found_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_drop_q  <= 1'b0;
			out_u_q     <= '0;
			out_v_q     <= '0;
		end else begin
			if (cfg_we) begin
				vc_q <= cfg_wdata;
			end
			// drop the output word once taken, unless a new one replaces it
			if (out_valid_q && bridges.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			if (visit) begin
				vis_q[vnode] <= 1'b1;
				node_q  <= vnode;
				par_q   <= vpar;
				low_q   <= timer_q;
				disc_q  <= timer_q;
				timer_q <= timer_q + 1'b1;
			end
			unique case (state_q)
				gbf_pkg::ST_IDLE: begin
					if (acc) begin
						u_q    <= edges.end_u;
						v_q    <= edges.end_v;
						last_q <= edges.last_edge;
						if (edges.has_edge && bad_edge) begin
							drop_q <= 1'b1;
						end
					end
				end
				gbf_pkg::ST_L1: begin
					hv_q[u_q] <= 1'b1;
				end
				gbf_pkg::ST_L3: begin
					hv_q[v_q] <= 1'b1;
					et_q      <= et_q + 1'b1;
				end
				gbf_pkg::ST_ROOT: begin
					if (root_q < nv && vis_q[root_q[gbf_pkg::VtxW-1:0]]) begin
						root_q <= root_q + 1'b1;
					end
				end
				gbf_pkg::ST_HEAD: begin
					cur_q <= hv_q[node_q] ? {1'b0, ht_rd.head} : gbf_pkg::NilLink;
				end
				gbf_pkg::ST_CUR: begin
					if (cur_q[gbf_pkg::LinkW-1]) begin
						if (depth_q == '0) begin
							root_q <= root_q + 1'b1;
						end else begin
							depth_q <= depth_q - 1'b1;
						end
					end
				end
				gbf_pkg::ST_NB: begin
					// advance the cursor; on a tree edge, suspend this frame
					if (!hit_parent && !vis_q[nb_rd]) begin
						depth_q <= depth_q + 1'b1;
					end else begin
						cur_q <= nx_rd;
					end
				end
				gbf_pkg::ST_DISC: begin
					if (disc_rd < low_q) begin
						low_q <= disc_rd;
					end
				end
				gbf_pkg::ST_POP: begin
					if (!pop_stall) begin
						node_q <= stk_rd.vertex;
						par_q  <= stk_rd.parent;
						cur_q  <= stk_rd.cursor;
						disc_q <= stk_rd.disc;
						low_q  <= (low_q < stk_rd.low) ? low_q : stk_rd.low;
						if (bridge) begin
							if (pend_q) begin
								out_valid_q <= 1'b1;
								out_found_q <= 1'b1;
								out_u_q     <= pend_u_q;
								out_v_q     <= pend_v_q;
								out_last_q  <= 1'b0;
								out_drop_q  <= drop_q;
							end
							pend_q   <= 1'b1;
							pend_u_q <= stk_rd.vertex;
							pend_v_q <= node_q;
						end
					end
				end
				gbf_pkg::ST_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_found_q <= pend_q;
						out_u_q     <= pend_q ? pend_u_q : '0;
						out_v_q     <= pend_q ? pend_v_q : '0;
						out_last_q  <= 1'b1;
						out_drop_q  <= drop_q;
						// clear every mark and counter for the next run
						et_q    <= '0;
						drop_q  <= 1'b0;
						vis_q   <= '0;
						hv_q    <= '0;
						depth_q <= '0;
						timer_q <= '0;
						root_q  <= '0;
						pend_q  <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// A push never overflows the suspended-frame memory.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbf_pkg::ST_NB && !hit_parent && !vis_q[nb_rd]) |-> (depth_q != '1))
		else $error("stack overflow");

	// A word without a bridge is always the final word of a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_found_q) |-> out_last_q)
		else $error("empty result not final");

	// Finishing a run leaves all marks cleared.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gbf_pkg::ST_FINISH && out_free) |=> (vis_q == '0 && hv_q == '0 && !pend_q))
		else $error("stores not cleared");

	// No input is taken while the walk holds a pending bridge.
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> !edges.ready)
		else $error("input accepted mid-walk");

endmodule
